### hdl/glr_pkg.sv
// Shared types and constants of the gradient line rasterizer.
package glr_pkg;

    localparam int CHAN_BITS  = 8;
    localparam int CHAN_COUNT = 3;
    localparam int COLOR_BITS = CHAN_BITS * CHAN_COUNT;
    localparam int WIN_BITS   = 15;
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;

    localparam logic [WIN_BITS-1:0] WIDTH_RESET  = 15'd1920;
    localparam logic [WIN_BITS-1:0] HEIGHT_RESET = 15'd1080;

    localparam logic REG_WINDOW_WIDTH  = 1'b0;
    localparam logic REG_WINDOW_HEIGHT = 1'b1;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    typedef struct packed {
        logic [WIN_BITS-1:0] width;
        logic [WIN_BITS-1:0] height;
    } win_cfg_t;

endpackage

### hdl/glr_req_if.sv
// Request channel: line loads and pixel steps.
interface glr_req_if
    import glr_pkg::*;
#(
    parameter int COORD_BITS = 16
) ();

    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0]        start_color;
    logic [COLOR_BITS-1:0]        end_color;

    modport source (
        output valid, req_type, start_x, start_y, end_x, end_y, start_color, end_color,
        input  ready
    );

    modport sink (
        input  valid, req_type, start_x, start_y, end_x, end_y, start_color, end_color,
        output ready
    );

endinterface

### hdl/glr_pix_if.sv
// Pixel channel: one emitted pixel per accepted step on an active line.
interface glr_pix_if
    import glr_pkg::*;
#(
    parameter int COORD_BITS = 16
) ();

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0]        pixel_color;
    logic                         on_screen;
    logic                         last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, on_screen, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, on_screen, last_pixel,
        output ready
    );

endinterface

### hdl/glr_apb.sv
// APB register file holding the window size.
module glr_apb
    import glr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    output win_cfg_t              cfg
);

    win_cfg_t cfg_reg;
    logic     reg_idx;
    logic     wr_en;

    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= WIDTH_RESET;
            cfg_reg.height <= HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_WINDOW_WIDTH:  cfg_reg.width  <= pwdata[WIN_BITS-1:0];
                REG_WINDOW_HEIGHT: cfg_reg.height <= pwdata[WIN_BITS-1:0];
                default:           cfg_reg        <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WINDOW_WIDTH:  prdata = PDATA_BITS'(cfg_reg.width);
            REG_WINDOW_HEIGHT: prdata = PDATA_BITS'(cfg_reg.height);
            default:           prdata = '0;
        endcase
    end

endmodule

### hdl/glr_div.sv
// Radix-2 restoring divider for one color channel, one quotient bit per cycle while shift is high.
module glr_div
    import glr_pkg::*;
#(
    parameter int DEN_BITS = 16
) (
    input  logic                         clk,
    input  logic                         load,
    input  logic                         shift,
    input  logic [CHAN_BITS+DEN_BITS-1:0] num,
    input  logic [DEN_BITS-1:0]          den,
    output logic [CHAN_BITS-1:0]         quo
);

    // quotient is known to fit CHAN_BITS, so the top of num starts below den
    logic [DEN_BITS-1:0]  rem_reg;
    logic [CHAN_BITS-1:0] lo_reg;
    logic [DEN_BITS:0]    trial;
    logic [DEN_BITS:0]    trial_sub;
    logic                 fits;

    assign trial     = {rem_reg, lo_reg[CHAN_BITS-1]};
    assign fits      = trial >= {1'b0, den};
    assign trial_sub = trial - {1'b0, den};
    assign quo       = lo_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= num[CHAN_BITS+DEN_BITS-1:CHAN_BITS];
            lo_reg  <= num[CHAN_BITS-1:0];
        end
        else if (shift)
        begin
            rem_reg <= fits ? trial_sub[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            lo_reg  <= {lo_reg[CHAN_BITS-2:0], fits};
        end
    end

endmodule

### hdl/gradient_line_rasterizer.sv
// Top level of the gradient line rasterizer: sequencer, line walker and color blend.
//
// A load request passes through ST_LOAD and gives no pixel. A step request on an
// active line passes through ST_MUL (multiply), ST_DIV (divider steps, one per
// quotient bit), ST_CAP (capture) and ST_OUT (pixel shown), and the block takes
// its next request the cycle after the pixel is taken. The divide is done by
// the three per-channel radix-2 dividers that produce one quotient bit per
// cycle. A step with no active line is accepted in ST_IDLE and gives nothing.
// Off-window pixels are emitted with on_screen low.
module gradient_line_rasterizer
    import glr_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    glr_req_if.sink               req,
    glr_pix_if.source             pix
);

    localparam int CW       = COORD_BITS;
    localparam int EW       = COORD_BITS + 3;
    localparam int CMP_BITS = (COORD_BITS > WIN_BITS) ? COORD_BITS : WIN_BITS;
    localparam int CNT_BITS = $clog2(CHAN_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(CHAN_BITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_DIV,
        ST_CAP,
        ST_OUT
    } state_t;

    state_t               state_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    win_cfg_t             cfg;

    logic [CW-1:0]         cur_x_reg;
    logic [CW-1:0]         cur_y_reg;
    logic                  x_neg_reg;
    logic                  y_neg_reg;
    logic [CW-1:0]         abs_x_reg;
    logic [CW-1:0]         abs_y_reg;
    logic [CW-1:0]         major_len_reg;
    logic                  x_major_reg;
    logic signed [EW-1:0]  err_reg;
    logic signed [EW-1:0]  err_move_reg;
    logic signed [EW-1:0]  err_stay_reg;
    logic [CW-1:0]         step_index_reg;
    logic [COLOR_BITS-1:0] color_from_reg;
    logic [COLOR_BITS-1:0] color_to_reg;
    logic                  line_active_reg;
    logic [CHAN_COUNT-1:0] dec_reg;

    logic [CW-1:0]         out_x_reg;
    logic [CW-1:0]         out_y_reg;
    logic [COLOR_BITS-1:0] out_color_reg;
    logic                  out_on_reg;
    logic                  out_last_reg;

    logic                  req_fire;
    logic [CW:0]           dx;
    logic [CW:0]           dy;
    logic [CW:0]           dx_neg;
    logic [CW:0]           dy_neg;
    logic                  load_x_major;
    logic [CW-1:0]         load_major;
    logic [CW-1:0]         load_minor;
    logic [EW-1:0]         minor_x2;
    logic [CW-1:0]         step_x;
    logic [CW-1:0]         step_y;
    logic                  minor_move;
    logic                  pix_last;
    logic                  pix_on;
    logic [CW-1:0]         step_index_inc;
    logic [COLOR_BITS-1:0] blend_color;
    logic [CHAN_COUNT-1:0] dec_next;
    logic                  div_load;
    logic                  div_shift;

    glr_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign div_load  = (state_reg == ST_MUL);
    assign div_shift = (state_reg == ST_DIV);

    // endpoint deltas, one bit wider than a coordinate
    assign dx     = {req.end_x[CW-1], req.end_x} - {req.start_x[CW-1], req.start_x};
    assign dy     = {req.end_y[CW-1], req.end_y} - {req.start_y[CW-1], req.start_y};
    assign dx_neg = -dx;
    assign dy_neg = -dy;

    assign load_x_major = abs_x_reg > abs_y_reg;
    assign load_major   = load_x_major ? abs_x_reg : abs_y_reg;
    assign load_minor   = load_x_major ? abs_y_reg : abs_x_reg;
    assign minor_x2     = {2'b00, load_minor, 1'b0};

    assign step_x         = x_neg_reg ? '1 : CW'(1);
    assign step_y         = y_neg_reg ? '1 : CW'(1);
    assign minor_move     = !err_reg[EW-1];
    assign step_index_inc = step_index_reg + CW'(1);
    assign pix_last       = (step_index_inc == major_len_reg);
    assign pix_on = !cur_x_reg[CW-1] && !cur_y_reg[CW-1] &&
                    (CMP_BITS'(cur_x_reg) < CMP_BITS'(cfg.width)) &&
                    (CMP_BITS'(cur_y_reg) < CMP_BITS'(cfg.height));

    for (genvar c = 0; c < CHAN_COUNT; c++)
    begin : g_chan
        logic [CHAN_BITS-1:0]    chan_a;
        logic [CHAN_BITS-1:0]    chan_b;
        logic [CHAN_BITS-1:0]    chan_diff;
        logic [CHAN_BITS+CW-1:0] chan_prod;
        logic [CHAN_BITS-1:0]    chan_q;

        assign chan_a      = color_from_reg[c*CHAN_BITS +: CHAN_BITS];
        assign chan_b      = color_to_reg[c*CHAN_BITS +: CHAN_BITS];
        assign dec_next[c] = chan_b < chan_a;
        assign chan_diff   = dec_next[c] ? (chan_a - chan_b) : (chan_b - chan_a);
        assign chan_prod   = (CHAN_BITS+CW)'(chan_diff) * (CHAN_BITS+CW)'(step_index_reg);
        assign blend_color[c*CHAN_BITS +: CHAN_BITS] =
            dec_reg[c] ? (chan_a - chan_q) : (chan_a + chan_q);

        glr_div #(
            .DEN_BITS (CW)
        ) u_div (
            .clk   (clk),
            .load  (div_load),
            .shift (div_shift),
            .num   (chan_prod),
            .den   (major_len_reg),
            .quo   (chan_q)
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            x_neg_reg       <= 1'b0;
            y_neg_reg       <= 1'b0;
            abs_x_reg       <= '0;
            abs_y_reg       <= '0;
            major_len_reg   <= '0;
            x_major_reg     <= 1'b0;
            err_reg         <= '0;
            err_move_reg    <= '0;
            err_stay_reg    <= '0;
            step_index_reg  <= '0;
            color_from_reg  <= '0;
            color_to_reg    <= '0;
            line_active_reg <= 1'b0;
            dec_reg         <= '0;
            out_x_reg       <= '0;
            out_y_reg       <= '0;
            out_color_reg   <= '0;
            out_on_reg      <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        if (req.req_type == REQ_LOAD)
                        begin
                            cur_x_reg      <= req.start_x;
                            cur_y_reg      <= req.start_y;
                            x_neg_reg      <= dx[CW];
                            y_neg_reg      <= dy[CW];
                            abs_x_reg      <= dx[CW] ? dx_neg[CW-1:0] : dx[CW-1:0];
                            abs_y_reg      <= dy[CW] ? dy_neg[CW-1:0] : dy[CW-1:0];
                            step_index_reg <= '0;
                            color_from_reg <= req.start_color;
                            color_to_reg   <= req.end_color;
                            state_reg      <= ST_LOAD;
                        end
                        else if (line_active_reg)
                        begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_LOAD:
                begin
                    x_major_reg     <= load_x_major;
                    major_len_reg   <= load_major;
                    err_reg         <= minor_x2 - {3'b000, load_major};
                    err_move_reg    <= minor_x2 - {2'b00, load_major, 1'b0};
                    err_stay_reg    <= minor_x2;
                    line_active_reg <= (load_major != '0);
                    state_reg       <= ST_IDLE;
                end
                ST_MUL:
                begin
                    dec_reg   <= dec_next;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + CNT_BITS'(1);
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_reg <= ST_CAP;
                    end
                end
                ST_CAP:
                begin
                    out_x_reg      <= cur_x_reg;
                    out_y_reg      <= cur_y_reg;
                    out_color_reg  <= blend_color;
                    out_on_reg     <= pix_on;
                    out_last_reg   <= pix_last;
                    err_reg        <= err_reg + (minor_move ? err_move_reg : err_stay_reg);
                    if (x_major_reg)
                    begin
                        cur_x_reg <= cur_x_reg + step_x;
                        if (minor_move)
                        begin
                            cur_y_reg <= cur_y_reg + step_y;
                        end
                    end
                    else
                    begin
                        cur_y_reg <= cur_y_reg + step_y;
                        if (minor_move)
                        begin
                            cur_x_reg <= cur_x_reg + step_x;
                        end
                    end
                    step_index_reg <= step_index_inc;
                    if (pix_last)
                    begin
                        line_active_reg <= 1'b0;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (pix.ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign pix.valid       = (state_reg == ST_OUT);
    assign pix.pixel_x     = out_x_reg;
    assign pix.pixel_y     = out_y_reg;
    assign pix.pixel_color = out_color_reg;
    assign pix.on_screen   = out_on_reg;
    assign pix.last_pixel  = out_last_reg;

    a_mul_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (line_active_reg && (major_len_reg != '0)))
        else $error("divide started without an active line");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.last_pixel) |-> !line_active_reg)
        else $error("line still active after its last pixel");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> (step_index_reg < major_len_reg))
        else $error("step index ran past line length");

    a_on_screen_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.on_screen) |-> (!pix.pixel_x[CW-1] && !pix.pixel_y[CW-1]))
        else $error("negative coordinate flagged on screen");

    a_div_to_cap: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) && (cnt_reg == CNT_LAST)) |=> (state_reg == ST_CAP))
        else $error("divider sequence did not finish");

endmodule

### tb/tb_top.sv
// Self-checking testbench of the gradient line rasterizer: directed and random traffic.
module tb_top;
    import glr_pkg::*;

    localparam int COORD_BITS = 16;
    localparam logic [PADDR_BITS-1:0] ADDR_WIDTH  = {REG_WINDOW_WIDTH, 2'b00};
    localparam logic [PADDR_BITS-1:0] ADDR_HEIGHT = {REG_WINDOW_HEIGHT, 2'b00};
    localparam int SETTLE_CYCLES = 20;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic                         kind;
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic signed [COORD_BITS-1:0] ex;
        logic signed [COORD_BITS-1:0] ey;
        logic [COLOR_BITS-1:0]        c0;
        logic [COLOR_BITS-1:0]        c1;
    } line_req_t;

    typedef struct {
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic [COLOR_BITS-1:0]        color;
        logic                         visible;
        logic                         is_last;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic pready;

    glr_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
    glr_pix_if #(.COORD_BITS(COORD_BITS)) pix_ch ();

    gradient_line_rasterizer #(
        .COORD_BITS(COORD_BITS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .pix     (pix_ch)
    );

    // walker model state
    int walk_x;
    int walk_y;
    bit neg_x;
    bit neg_y;
    int major_len;
    int minor_len;
    int err_term;
    int pix_index;
    bit major_is_x;
    logic [COLOR_BITS-1:0] col_from;
    logic [COLOR_BITS-1:0] col_to;
    bit line_busy;
    logic [WIN_BITS-1:0] win_w;
    logic [WIN_BITS-1:0] win_h;

    pixel_t pending_pixels[$];
    int mismatches;
    int useful_reqs;
    int gap_pct;
    int stall_pct;
    int hold_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void flag(input string what, input longint exp_v, input longint act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0h, got %0h", what, exp_v, act_v);
    endfunction

    function automatic int wrap_coord(input int v);
        logic signed [COORD_BITS-1:0] t;
        t = v[COORD_BITS-1:0];
        return int'(t);
    endfunction

    function automatic int blend(input int a, input int b, input int i, input int len);
        if (len == 0)
            return a;
        if (b >= a)
            return a + (b - a) * i / len;
        return a - (a - b) * i / len;
    endfunction

    // returns 0 when the request is a step that the block ignores
    function automatic bit rasterize(input line_req_t it);
        pixel_t p;
        int sx;
        int sy;
        int ex;
        int ey;
        int w;
        int h;
        int stepx;
        int stepy;
        int sh;
        bit move;
        if (it.kind == REQ_LOAD)
        begin
            sx = it.sx;
            sy = it.sy;
            ex = it.ex;
            ey = it.ey;
            w = (ex >= sx) ? ex - sx : sx - ex;
            h = (ey >= sy) ? ey - sy : sy - ey;
            walk_x = sx;
            walk_y = sy;
            neg_x = ex < sx;
            neg_y = ey < sy;
            major_is_x = w > h;
            major_len = major_is_x ? w : h;
            minor_len = major_is_x ? h : w;
            err_term = 2 * minor_len - major_len;
            pix_index = 0;
            col_from = it.c0;
            col_to = it.c1;
            line_busy = major_len != 0;
            return 1'b1;
        end
        if (!line_busy)
            return 1'b0;
        p.px = walk_x[COORD_BITS-1:0];
        p.py = walk_y[COORD_BITS-1:0];
        p.is_last = (pix_index + 1) == major_len;
        for (sh = 0; sh < COLOR_BITS; sh += CHAN_BITS)
            p.color[sh +: CHAN_BITS] = CHAN_BITS'(blend(int'(col_from[sh +: CHAN_BITS]),
                int'(col_to[sh +: CHAN_BITS]), pix_index, major_len));
        p.visible = walk_x >= 0 && walk_y >= 0 &&
                    walk_x < int'(win_w) && walk_y < int'(win_h);
        pending_pixels.push_back(p);
        stepx = neg_x ? -1 : 1;
        stepy = neg_y ? -1 : 1;
        move = err_term >= 0;
        err_term += move ? 2 * minor_len - 2 * major_len : 2 * minor_len;
        if (major_is_x)
        begin
            walk_x = wrap_coord(walk_x + stepx);
            if (move)
                walk_y = wrap_coord(walk_y + stepy);
        end
        else
        begin
            walk_y = wrap_coord(walk_y + stepy);
            if (move)
                walk_x = wrap_coord(walk_x + stepx);
        end
        pix_index++;
        if (p.is_last)
            line_busy = 1'b0;
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin : pixel_check
        pixel_t e;
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            if (pending_pixels.size() == 0)
                flag("unexpected pixel", 0, {pix_ch.pixel_x, pix_ch.pixel_y});
            else
            begin
                e = pending_pixels.pop_front();
                if (pix_ch.pixel_x !== e.px)
                    flag("pixel_x", e.px, pix_ch.pixel_x);
                if (pix_ch.pixel_y !== e.py)
                    flag("pixel_y", e.py, pix_ch.pixel_y);
                if (pix_ch.pixel_color !== e.color)
                    flag("pixel_color", e.color, pix_ch.pixel_color);
                if (pix_ch.on_screen !== e.visible)
                    flag("on_screen", e.visible, pix_ch.on_screen);
                if (pix_ch.last_pixel !== e.is_last)
                    flag("last_pixel", e.is_last, pix_ch.last_pixel);
            end
        end
    end

    // pixel receiver; a long hold-off counts down here
    initial
    begin
        pix_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                pix_ch.ready <= 1'b0;
            end
            else
                pix_ch.ready <= !(rst_n && $urandom_range(99) < stall_pct);
        end
    end

    function automatic line_req_t rand_req(input logic kind);
        line_req_t it;
        it.kind = kind;
        it.sx = COORD_BITS'($urandom);
        it.sy = COORD_BITS'($urandom);
        it.ex = COORD_BITS'($urandom);
        it.ey = COORD_BITS'($urandom);
        it.c0 = COLOR_BITS'($urandom);
        it.c1 = COLOR_BITS'($urandom);
        return it;
    endfunction

    function automatic line_req_t load_req(input int sx, input int sy, input int ex, input int ey,
                                           input int c0, input int c1);
        line_req_t it;
        it.kind = REQ_LOAD;
        it.sx = COORD_BITS'(sx);
        it.sy = COORD_BITS'(sy);
        it.ex = COORD_BITS'(ex);
        it.ey = COORD_BITS'(ey);
        it.c0 = COLOR_BITS'(c0);
        it.c1 = COLOR_BITS'(c1);
        return it;
    endfunction

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic send_req(input line_req_t it);
        while ($urandom_range(99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= it.kind;
        req_ch.start_x <= it.sx;
        req_ch.start_y <= it.sy;
        req_ch.end_x <= it.ex;
        req_ch.end_y <= it.ey;
        req_ch.start_color <= it.c0;
        req_ch.end_color <= it.c1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (rasterize(it))
            useful_reqs++;
        @(negedge clk);
    endtask

    task automatic send_steps(input int n);
        repeat (n)
            send_req(rand_req(REQ_STEP));
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [PADDR_BITS-1:0] addr,
                            input logic [PDATA_BITS-1:0] data,
                            output logic [PDATA_BITS-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_window(input int w, input int h);
        logic [PDATA_BITS-1:0] rd;
        wait_idle();
        apb_xfer(1'b1, ADDR_WIDTH, PDATA_BITS'(w), rd);
        win_w = WIN_BITS'(w);
        apb_xfer(1'b1, ADDR_HEIGHT, PDATA_BITS'(h), rd);
        win_h = WIN_BITS'(h);
        apb_xfer(1'b0, ADDR_WIDTH, '0, rd);
        if (rd[WIN_BITS-1:0] !== win_w)
            flag("window_width readback", win_w, rd[WIN_BITS-1:0]);
        apb_xfer(1'b0, ADDR_HEIGHT, '0, rd);
        if (rd[WIN_BITS-1:0] !== win_h)
            flag("window_height readback", win_h, rd[WIN_BITS-1:0]);
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin gap_pct = 62; stall_pct = 0;  end
            IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 62; end
            default:       begin gap_pct = 37; stall_pct = 37; end
        endcase
    endtask

    // reset window: line crossing the right and bottom edges, idle steps around it
    task automatic test_reset_window();
        send_steps(1);
        send_req(load_req(1917, 1078, 1922, 1080, 24'h102030, 24'hF0E0D0));
        send_steps(6);
    endtask

    task automatic test_zero_length();
        send_req(load_req(7, 7, 7, 7, 24'hFFFFFF, 24'h000000));
        send_steps(1);
    endtask

    // |dx| == |dy| walks y, both directions negative
    task automatic test_tie_negative();
        send_req(load_req(2, 2, -1, -1, 24'hFFFFFF, 24'h000000));
        send_steps(4);
    endtask

    // full-range lines, each abandoned by the next load
    task automatic test_coord_extremes();
        send_req(load_req(-32768, 32767, 32767, -32768, 24'h000000, 24'hFFFFFF));
        send_steps(2);
        send_req(load_req(32767, -32768, -32768, -32767, 24'hFF00FF, 24'h00FF00));
        send_steps(2);
    endtask

    task automatic test_window_zero();
        set_window(0, 0);
        send_req(load_req(0, 0, 1, 0, 24'h123456, 24'h654321));
        send_steps(1);
    endtask

    // receiver holds off while steps keep coming
    task automatic test_backpressure();
        set_window(200, 200);
        set_idling(IDLE_NONE);
        send_req(load_req(0, 0, 100, 37, 24'h00FF80, 24'hFF0080));
        hold_left = 300;
        send_steps(40);
        wait_idle();
    endtask

    task automatic test_random_traffic(input idle_mode_t mode, input int w, input int h,
                                       input int target);
        line_req_t it;
        int goal;
        int r;
        int sx;
        int sy;
        int dx;
        int dy;
        int len;
        set_window(w, h);
        set_idling(mode);
        goal = useful_reqs + target;
        while (useful_reqs < goal)
        begin
            r = $urandom_range(99);
            if (r < 10)
                send_req(rand_req(1'($urandom_range(1))));
            else if (r < 25)
            begin
                send_req(rand_req(REQ_LOAD));
                send_steps($urandom_range(1, 8));
            end
            else
            begin
                sx = $urandom_range(0, 72) - 12;
                sy = $urandom_range(0, 72) - 12;
                dx = $urandom_range(0, 40) - 20;
                dy = $urandom_range(0, 40) - 20;
                it = rand_req(REQ_LOAD);
                it.sx = COORD_BITS'(sx);
                it.sy = COORD_BITS'(sy);
                it.ex = COORD_BITS'(sx + dx);
                it.ey = COORD_BITS'(sy + dy);
                send_req(it);
                len = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                                  : (dy < 0 ? -dy : dy);
                if (r < 85)
                    send_steps(len + $urandom_range(0, 1));
                else
                    send_steps($urandom_range(0, len));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_LOAD;
        req_ch.start_x = '0;
        req_ch.start_y = '0;
        req_ch.end_x = '0;
        req_ch.end_y = '0;
        req_ch.start_color = '0;
        req_ch.end_color = '0;
        mismatches = 0;
        useful_reqs = 0;
        hold_left = 0;
        gap_pct = 0;
        stall_pct = 0;
        win_w = WIDTH_RESET;
        win_h = HEIGHT_RESET;
        walk_x = 0;
        walk_y = 0;
        neg_x = 0;
        neg_y = 0;
        major_len = 0;
        minor_len = 0;
        err_term = 0;
        pix_index = 0;
        major_is_x = 0;
        col_from = '0;
        col_to = '0;
        line_busy = 0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_window();
        test_zero_length();
        test_tie_negative();
        test_coord_extremes();
        test_window_zero();
        test_backpressure();
        test_random_traffic(IDLE_NONE, 32767, 32767, 470);
        test_random_traffic(IDLE_SENDER, 1, 1, 470);
        test_random_traffic(IDLE_RECEIVER, $urandom_range(8, 64), $urandom_range(8, 64), 470);
        test_random_traffic(IDLE_BOTH, $urandom_range(1, 32767), $urandom_range(16, 48), 470);

        set_idling(IDLE_NONE);
        wait_idle();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
